@@ src/rbc_pkg.sv @@
package rbc_pkg;

    localparam int DEF_MAX_ROTORS = 16;

    localparam logic [1:0] OP_LOAD_ENTRY  = 2'd0;
    localparam logic [1:0] OP_LOAD_OFFSET = 2'd1;
    localparam logic [1:0] OP_PROCESS     = 2'd2;

    localparam logic REG_DIRECTION   = 1'b0;
    localparam logic REG_ROTOR_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [7:0] load_val;
    } cell_ctl_t;

    // inverse in GF(16) mod x^4+x+1, inv(0) = 0
    function automatic logic [3:0] gf16_inv(input logic [3:0] a);
        logic [3:0] r;
        case (a)
            4'h0: r = 4'h0;
            4'h1: r = 4'h1;
            4'h2: r = 4'h9;
            4'h3: r = 4'hE;
            4'h4: r = 4'hD;
            4'h5: r = 4'hB;
            4'h6: r = 4'h7;
            4'h7: r = 4'h6;
            4'h8: r = 4'hF;
            4'h9: r = 4'h2;
            4'hA: r = 4'hC;
            4'hB: r = 4'h5;
            4'hC: r = 4'hA;
            4'hD: r = 4'h4;
            4'hE: r = 4'h3;
            default: r = 4'h8;
        endcase
        return r;
    endfunction

endpackage

@@ src/rbc_cell.sv @@
module rbc_cell
    import rbc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       active,
    input  logic [3:0] own_nib,
    input  logic [3:0] mirror_nib,
    output logic [7:0] offset
);

    localparam logic [7:0] INC = 8'((2 * IDX + 1) % 256);

    logic [7:0] offset_reg;
    logic [7:0] offset_next;
    logic [3:0] v;

    always_comb
    begin
        v           = gf16_inv(own_nib) ^ mirror_nib;
        offset_next = offset_reg;
        if (ctl.load)
        begin
            offset_next = ctl.load_val;
        end
        else if (ctl.step && active && (^v))
        begin
            offset_next = offset_reg + INC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 8'd0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    assign offset = offset_reg;

endmodule

@@ src/rotor_byte_cipher_top.sv @@
// channel | signals                                   | dir
// in      | in_valid, in_ready, opcode, rotor_index,  | in
//         | entry_index, value                        |
// out     | out_valid, out_ready, out_byte            | out
// cfg     | cfg_write, cfg_index, cfg_data            | in
// Loads end on acceptance. A data byte goes through ST_READ (one read of the
// single table RAM) and ST_DATA (take registered read data) per active rotor,
// then ST_FIN; no request is taken meanwhile. Offsets step in the cell row as the
// result is registered. Reset clears offsets and control, not the table RAM.
// A pending result blocks only the end of the next data byte, not its start.
module rotor_byte_cipher_top
    import rbc_pkg::*;
#(
    parameter int MAX_ROTORS = DEF_MAX_ROTORS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] rotor_index,
    input  logic [7:0] entry_index,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    localparam int CW    = $clog2(MAX_ROTORS + 1);
    localparam int IW    = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int NW    = $clog2(2 * MAX_ROTORS);
    localparam int AW    = $clog2(MAX_ROTORS * 256);
    localparam int DEPTH = MAX_ROTORS * 256;

    state_t state_reg, state_next;

    logic          dir_reg;
    logic [4:0]    count_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    b_reg, b_next;
    logic [7:0]    rd_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;

    logic [7:0]    mem [DEPTH];

    logic [CW-1:0] n_act;
    logic          accept;
    logic          rot_ok;
    logic          fin_go;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    offs [MAX_ROTORS];
    logic [3:0]    nib [2*MAX_ROTORS];
    logic [CW-1:0] rev_idx;

    assign n_act  = (32'(count_reg) > MAX_ROTORS) ? CW'(MAX_ROTORS) : CW'(count_reg);
    assign accept = in_valid && in_ready;
    assign rot_ok = 32'(rotor_index) < MAX_ROTORS;
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign rev_idx = n_act - 1'b1 - cnt_reg;

    assign rd_addr = AW'({cnt_reg, (dir_reg ? b_reg : b_reg + offs[cnt_reg[IW-1:0]])});
    assign wr_addr = AW'({rotor_index, entry_index});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 1'b0;
            count_reg <= 5'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DIRECTION:   dir_reg   <= cfg_data[0];
                REG_ROTOR_COUNT: count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD_ENTRY && rot_ok)
        begin
            mem[wr_addr] <= value;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_PROCESS)
                begin
                    state_next = (n_act == '0) ? ST_FIN : ST_READ;
                end
            end
            ST_READ: state_next = ST_DATA;
            ST_DATA: state_next = (cnt_reg + 1'b1 == n_act) ? ST_FIN : ST_READ;
            ST_FIN:  state_next = fin_go ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    b_next   = value;
                end
            end
            ST_DATA:
            begin
                cnt_next = cnt_reg + 1'b1;
                b_next   = dir_reg ? rd_reg - offs[rev_idx[IW-1:0]] : rd_reg;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        if (fin_go)
        begin
            out_byte_reg <= b_reg;
        end
    end

    // offset row: nibble sequence low/high per rotor
    always_comb
    begin
        for (int k = 0; k < MAX_ROTORS; k++)
        begin
            nib[2*k]   = offs[k][3:0];
            nib[2*k+1] = offs[k][7:4];
        end
    end

    for (genvar i = 0; i < MAX_ROTORS; i++)
    begin : g_cell
        cell_ctl_t     ctl;
        logic [CW:0]   mir;

        assign mir          = {n_act, 1'b0} - (CW+1)'(1) - (CW+1)'(i);
        assign ctl.load     = accept && opcode == OP_LOAD_OFFSET && rot_ok
                              && (32'(rotor_index) == i);
        assign ctl.step     = fin_go;
        assign ctl.load_val = value;

        rbc_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .active     (32'(n_act) > i),
            .own_nib    (nib[i]),
            .mirror_nib (nib[mir[NW-1:0]]),
            .offset     (offs[i])
        );
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

@@ src/rbc_chk.sv @@
module rbc_chk
    import rbc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("result changed while stalled");

    a_proc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_PROCESS |=> !in_ready)
        else $error("request taken during data byte");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode != OP_PROCESS |=> in_ready)
        else $error("load request did not complete in one cycle");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without data byte in flight");

endmodule

bind rotor_byte_cipher_top rbc_chk u_rbc_chk (.*);

@@ verif/rbc_checker.sv @@
module rbc_checker
    import rbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] rotor_index,
    input  logic [7:0] entry_index,
    input  logic [7:0] value,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    output int         mismatches,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTORS = 16;
    localparam logic [3:0] GF_INV [16] = '{4'h0, 4'h1, 4'h9, 4'hE, 4'hD, 4'hB, 4'h7, 4'h6,
                                           4'hF, 4'h2, 4'hC, 4'h5, 4'hA, 4'h4, 4'h3, 4'h8};

    logic [7:0] table_mem [ROTORS*256];
    logic [7:0] offs [ROTORS];
    logic       decrypt;
    logic [4:0] rotors_cfg;
    logic [7:0] expected_bytes [$];

    function automatic int live_rotors();
        return (rotors_cfg > ROTORS) ? ROTORS : int'(rotors_cfg);
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] din);
        int n;
        logic [7:0] b;
        n = live_rotors();
        b = din;
        for (int i = 0; i < n; i++)
        begin
            if (decrypt)
                b = table_mem[i*256 + b] - offs[n-1-i];
            else
                b = table_mem[i*256 + 8'(b + offs[i])];
        end
        return b;
    endfunction

    function automatic void advance_offsets();
        int n;
        logic [3:0] nib [2*ROTORS];
        logic [3:0] v;
        n = live_rotors();
        for (int i = 0; i < n; i++)
        begin
            nib[2*i]   = offs[i][3:0];
            nib[2*i+1] = offs[i][7:4];
        end
        for (int i = 0; i < n; i++)
        begin
            v = GF_INV[nib[i]] ^ nib[2*n-1-i];
            if (^v)
                offs[i] = offs[i] + 8'(2*i + 1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (offs[i]) offs[i] = '0;
            decrypt = 1'b0;
            rotors_cfg = 5'd1;
            expected_bytes.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_DIRECTION)
                    decrypt = cfg_data[0];
                else
                    rotors_cfg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: unexpected result, actual %0h", out_byte);
                    mismatches++;
                end
                else
                begin
                    logic [7:0] exp_b;
                    exp_b = expected_bytes.pop_front();
                    if (out_byte !== exp_b)
                    begin
                        $error("out_byte: expected %0h, actual %0h", exp_b, out_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_LOAD_ENTRY:  table_mem[rotor_index*256 + entry_index] = value;
                    OP_LOAD_OFFSET: offs[rotor_index] = value;
                    OP_PROCESS:
                    begin
                        expected_bytes = {expected_bytes, cipher_byte(value)};
                        advance_offsets();
                    end
                    default: ;
                endcase
            end
        end
        pending = expected_bytes.size();
    end

endmodule

@@ verif/tb_rotor_byte_cipher_top.sv @@
module tb_rotor_byte_cipher_top;
    import rbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int FILLED_ROTORS = 4;
    localparam int PHASE_REQUESTS = 50;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = '0;
    logic [3:0] rotor_index = '0;
    logic [7:0] entry_index = '0;
    logic [7:0] value = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    int         mismatches;
    int         pending;
    logic       quiet = 1'b0;
    logic       long_hold = 1'b0;
    int         idle_cycles = 0;

    always #5 clk = ~clk;

    rotor_byte_cipher_top u_dut (.*);

    rbc_checker u_chk (.*);

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (quiet || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_rotor_byte_cipher_top failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [3:0] rot,
                                input logic [7:0] ent, input logic [7:0] val);
        int gap;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= op;
        rotor_index <= rot;
        entry_index <= ent;
        value       <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [4:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_request(OP_PROCESS, 4'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 85)
            send_request(OP_LOAD_ENTRY, 4'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 95)
            send_request(OP_LOAD_OFFSET, 4'($urandom), 8'($urandom), 8'($urandom));
        else
            send_request(OP_UNUSED, 4'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        logic [4:0] counts [7];
        counts = '{5'd1, 5'd4, 5'd3, 5'd0, 5'd2, 5'd4, 5'd1};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the tables of every rotor in use so no unwritten entry is read
        for (int r = 0; r < FILLED_ROTORS; r++)
            for (int e = 0; e < 256; e++)
                send_request(OP_LOAD_ENTRY, 4'(r), 8'(e), 8'($urandom));

        drain();
        write_cfg(REG_ROTOR_COUNT, 5'(FILLED_ROTORS));
        write_cfg(REG_DIRECTION, 5'd0);
        send_request(OP_LOAD_OFFSET, 4'd0, 8'd0, 8'hFF);
        send_request(OP_LOAD_OFFSET, 4'd15, 8'hFF, 8'h00);
        send_request(OP_LOAD_ENTRY, 4'd15, 8'hFF, 8'hFF);
        send_request(OP_LOAD_ENTRY, 4'd0, 8'd0, 8'h00);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'h00);
        send_request(OP_PROCESS, 4'd15, 8'hFF, 8'hFF);
        send_request(OP_UNUSED, 4'd15, 8'hFF, 8'hFF);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'h5A);
        drain();
        write_cfg(REG_DIRECTION, 5'd1);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'h00);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'hFF);
        drain();
        write_cfg(REG_ROTOR_COUNT, 5'd0);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'hA5);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'h3C);
        drain();
        write_cfg(REG_ROTOR_COUNT, 5'd1);
        send_request(OP_PROCESS, 4'd0, 8'd0, 8'h01);

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_cfg(REG_DIRECTION, 5'(ph[0]));
            write_cfg(REG_ROTOR_COUNT, counts[ph]);
            if (ph == 1)
                long_hold = 1'b1;
            if (ph == 6)
                quiet = 1'b1;
            repeat (PHASE_REQUESTS) random_request();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_rotor_byte_cipher_top passed");
        else
            $display("tb_rotor_byte_cipher_top failed");
        $finish;
    end

endmodule
